@@ design/gidp_pkg.sv @@
package gidp_pkg;

   localparam int ElemWidth    = 8;
   localparam int ScaleWidth   = 32;
   localparam int GroupWidth   = 32;
   localparam int RowWidth     = 64;
   localparam int FracBits     = 24;
   localparam int ReqDataWidth = 2 * ElemWidth + 2 * ScaleWidth;
   localparam int QueueDepth   = 4;

   // one closed group waiting for its fold
   typedef struct packed {
      logic                  row_end;
      logic [ScaleWidth-1:0] act_scale;
      logic [ScaleWidth-1:0] weight_scale;
      logic [GroupWidth-1:0] group_sum;
   } fold_req_type;

endpackage

@@ design/gidp_front.sv @@
module gidp_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [gidp_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                            req_tuser,
   input  logic                            req_tlast,
   input  logic                            queue_full,
   output logic                            push,
   output gidp_pkg::fold_req_type          push_data
);
   import gidp_pkg::*;

   logic [GroupWidth-1:0]       group_sum_ff;
   logic [GroupWidth-1:0]       group_sum_in;
   logic signed [ElemWidth-1:0] weight_value;
   logic signed [ElemWidth-1:0] act_value;
   logic signed [2*ElemWidth-1:0] product;
   logic [GroupWidth-1:0]       total;
   logic                        accept;
   logic                        closes_group;

   assign weight_value = req_tdata[ElemWidth-1:0];
   assign act_value    = req_tdata[2*ElemWidth-1:ElemWidth];
   assign product      = weight_value * act_value;
   assign total        = group_sum_ff + GroupWidth'(product);

   assign req_tready   = !queue_full;
   assign accept       = req_tvalid && req_tready;
   assign closes_group = req_tuser || req_tlast;

   assign push                   = accept && closes_group;
   assign push_data.row_end      = req_tlast;
   assign push_data.weight_scale = req_tdata[2*ElemWidth+ScaleWidth-1:2*ElemWidth];
   assign push_data.act_scale    = req_tdata[ReqDataWidth-1:2*ElemWidth+ScaleWidth];
   assign push_data.group_sum    = total;

   always_comb begin
      group_sum_in = group_sum_ff;
      if (accept) begin
         group_sum_in = closes_group ? '0 : total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_sum_ff <= '0;
      end else begin
         group_sum_ff <= group_sum_in;
      end
   end

endmodule

@@ design/gidp_queue.sv @@
module gidp_queue #(
   parameter int DEPTH = gidp_pkg::QueueDepth
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  gidp_pkg::fold_req_type push_data,
   input  logic                   pop,
   output gidp_pkg::fold_req_type pop_data,
   output logic                   full,
   output logic                   empty
);
   import gidp_pkg::*;

   localparam int PtrWidth   = $clog2(DEPTH);
   localparam int CountWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0]   LastSlot  = PtrWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   fold_req_type          slots_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff;
   logic [PtrWidth-1:0]   wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff;
   logic [PtrWidth-1:0]   rd_ptr_in;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full     = (count_ff == FullCount);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

@@ design/gidp_back.sv @@
module gidp_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              queue_empty,
   input  gidp_pkg::fold_req_type            queue_data,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [gidp_pkg::RowWidth-1:0]     rsp_tdata
);
   import gidp_pkg::*;

   localparam int ScaleProdWidth = 2 * ScaleWidth;
   localparam int ProdWidth      = GroupWidth + ScaleProdWidth;
   localparam int TermWidth      = ProdWidth + 1 - FracBits;
   localparam int SumWidth       = TermWidth + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_COMBINE,
      ST_NEGATE,
      ST_ACCUM
   } state_type;

   state_type                  state_ff;
   logic                       row_end_ff;
   logic                       neg_ff;
   logic [GroupWidth-1:0]      mag_ff;
   logic [ScaleWidth-1:0]      weight_scale_ff;
   logic [ScaleWidth-1:0]      act_scale_ff;
   logic [ScaleProdWidth-1:0]  scale_prod_ff;
   logic [ScaleProdWidth-1:0]  part_lo_ff;
   logic [ScaleProdWidth-1:0]  part_hi_ff;
   logic [ProdWidth-1:0]       prod_ff;
   logic signed [TermWidth-1:0] term_ff;
   logic signed [RowWidth-1:0] row_sum_ff;
   logic                       rsp_valid_ff;
   logic [RowWidth-1:0]        rsp_data_ff;

   logic [ProdWidth:0]         signed_prod;
   logic signed [SumWidth-1:0] row_total;
   logic signed [RowWidth-1:0] row_sat;
   logic                       out_free;
   logic                       rsp_load;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_ACCUM) && row_end_ff && out_free;
   assign pop        = (state_ff == ST_IDLE) && !queue_empty;

   // two's complement of the magnitude product, then floor shift to Q.24
   always_comb begin
      signed_prod = {1'b0, prod_ff};
      if (neg_ff) begin
         signed_prod = ~signed_prod + 1'b1;
      end
   end

   // exact add, then clamp to the 64-bit range
   always_comb begin
      row_total = SumWidth'(row_sum_ff) + SumWidth'(term_ff);
      if (row_total[SumWidth-1:RowWidth-1] == '0 || row_total[SumWidth-1:RowWidth-1] == '1) begin
         row_sat = row_total[RowWidth-1:0];
      end else if (row_total[SumWidth-1]) begin
         row_sat = {1'b1, {(RowWidth-1){1'b0}}};
      end else begin
         row_sat = {1'b0, {(RowWidth-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         row_sum_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!queue_empty) begin
                  row_end_ff      <= queue_data.row_end;
                  weight_scale_ff <= queue_data.weight_scale;
                  act_scale_ff    <= queue_data.act_scale;
                  neg_ff          <= queue_data.group_sum[GroupWidth-1];
                  mag_ff          <= queue_data.group_sum[GroupWidth-1]
                                     ? (~queue_data.group_sum + 1'b1)
                                     : queue_data.group_sum;
                  state_ff        <= ST_SCALE;
               end
            end
            ST_SCALE: begin
               scale_prod_ff <= ScaleProdWidth'(weight_scale_ff) * ScaleProdWidth'(act_scale_ff);
               state_ff      <= ST_MUL_LO;
            end
            ST_MUL_LO: begin
               part_lo_ff <= ScaleProdWidth'(mag_ff) *
                             ScaleProdWidth'(scale_prod_ff[ScaleWidth-1:0]);
               state_ff   <= ST_MUL_HI;
            end
            ST_MUL_HI: begin
               part_hi_ff <= ScaleProdWidth'(mag_ff) *
                             ScaleProdWidth'(scale_prod_ff[ScaleProdWidth-1:ScaleWidth]);
               state_ff   <= ST_COMBINE;
            end
            ST_COMBINE: begin
               prod_ff  <= ProdWidth'(part_lo_ff) + {part_hi_ff, {ScaleWidth{1'b0}}};
               state_ff <= ST_NEGATE;
            end
            ST_NEGATE: begin
               term_ff  <= signed_prod[ProdWidth:FracBits];
               state_ff <= ST_ACCUM;
            end
            ST_ACCUM: begin
               if (!row_end_ff) begin
                  row_sum_ff <= row_sat;
                  state_ff   <= ST_IDLE;
               end else if (out_free) begin
                  rsp_data_ff  <= row_sat;
                  rsp_valid_ff <= 1'b1;
                  row_sum_ff   <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

@@ design/grouped_int8_dot_product.sv @@
// Grouped int8 dot product with per-group Q8.24 scales.
// Input stream (req_*): one word per vector element carrying a weight byte,
// an activation byte and the two group scales; tuser marks the end of a
// quantization group, tlast the end of an output row (which also ends the
// group). Scales are only sampled on words that close a group.
// Output stream (rsp_*): one word per row, the saturated Q39.24 row value.
// Throughput: one element per cycle into the int8 multiply-accumulate while
// req_tready is high. Each closed group is handed through a QUEUE_DEPTH-entry
// queue to a fold unit that takes one group at a time (three 32x32 multiplies
// in turn, then wide add, negate/shift and saturating accumulate), so groups
// that close faster than the fold unit retires them fill the queue and
// deassert req_tready. After a tlast word is taken, its group passes through
// the queue and the fold states before the row value is registered on
// rsp_tdata; a row end waits in ACCUM while a previous row is unaccepted.
// Reset clears the group sum, row sum, queue and output valid flag.
// A stalled rsp_tready holds the finished row; the front keeps taking
// elements until the queue fills.
module grouped_int8_dot_product #(
   parameter int QUEUE_DEPTH = gidp_pkg::QueueDepth
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // weight_value[7:0], act_value[15:8], weight_scale[47:16], act_scale[79:48]
   input  logic [gidp_pkg::ReqDataWidth-1:0] req_tdata,
   // group_end
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // row_value[63:0]
   output logic [gidp_pkg::RowWidth-1:0]     rsp_tdata
);
   import gidp_pkg::*;

   fold_req_type push_data;
   fold_req_type pop_data;
   logic         push;
   logic         pop;
   logic         queue_full;
   logic         queue_empty;

   gidp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   gidp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (queue_full),
      .empty     (queue_empty)
   );

   gidp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_data  (pop_data),
      .pop         (pop),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule
